/* rtl/irr_pkg.sv */
// Types and constants shared by the image region rotate block.
package irr_pkg;

    localparam int MAX_DIM    = 256;
    localparam int COORD_BITS = 8;
    localparam int SIZE_BITS  = 9;
    localparam int PIX_BITS   = 8;
    localparam int ADDR_BITS  = 2 * COORD_BITS;
    localparam int MEM_DEPTH  = MAX_DIM * MAX_DIM;

    typedef enum logic [1:0] {
        ACT_NEW    = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_READ   = 2'd2,
        ACT_ROTATE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SEL  = 2'd1,
        ST_NOT_ROT  = 2'd2,
        ST_BAD_ADDR = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_COPY_OUT,
        S_DRAIN_OUT,
        S_COPY_BACK,
        S_DRAIN_BACK,
        S_RESULT
    } t_state;

    typedef struct packed {
        t_action               action;
        logic [COORD_BITS-1:0] pixel_row;
        logic [COORD_BITS-1:0] pixel_col;
        logic [PIX_BITS-1:0]   pixel_in;
        logic [SIZE_BITS-1:0]  new_width;
        logic [SIZE_BITS-1:0]  new_height;
        logic [SIZE_BITS-1:0]  sel_left;
        logic [SIZE_BITS-1:0]  sel_top;
        logic [SIZE_BITS-1:0]  sel_right;
        logic [SIZE_BITS-1:0]  sel_bottom;
    } t_item;

    typedef struct packed {
        logic [PIX_BITS-1:0]  pixel_out;
        t_status              status;
        logic [SIZE_BITS-1:0] cur_width;
        logic [SIZE_BITS-1:0] cur_height;
    } t_result;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic copy_out;
        logic copy_back;
        logic swap_dims;
        logic load_result;
    } t_cmd;

    typedef struct packed {
        logic rotate_go;
        logic copy_last;
        logic out_free;
    } t_stat;

endpackage

/* rtl/irr_if.sv */
// Valid/ready channel interfaces for the item and result transactions.
interface irr_item_if import irr_pkg::*; ;
    logic                  valid;
    logic                  ready;
    t_action               action;
    logic [COORD_BITS-1:0] pixel_row;
    logic [COORD_BITS-1:0] pixel_col;
    logic [PIX_BITS-1:0]   pixel_in;
    logic [SIZE_BITS-1:0]  new_width;
    logic [SIZE_BITS-1:0]  new_height;
    logic [SIZE_BITS-1:0]  sel_left;
    logic [SIZE_BITS-1:0]  sel_top;
    logic [SIZE_BITS-1:0]  sel_right;
    logic [SIZE_BITS-1:0]  sel_bottom;

    modport source (
        output valid, action, pixel_row, pixel_col, pixel_in, new_width, new_height,
               sel_left, sel_top, sel_right, sel_bottom,
        input  ready
    );
    modport sink (
        input  valid, action, pixel_row, pixel_col, pixel_in, new_width, new_height,
               sel_left, sel_top, sel_right, sel_bottom,
        output ready
    );
endinterface

interface irr_result_if import irr_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [PIX_BITS-1:0]  pixel_out;
    t_status              status;
    logic [SIZE_BITS-1:0] cur_width;
    logic [SIZE_BITS-1:0] cur_height;

    modport source (
        output valid, pixel_out, status, cur_width, cur_height,
        input  ready
    );
    modport sink (
        input  valid, pixel_out, status, cur_width, cur_height,
        output ready
    );
endinterface

/* rtl/irr_ctrl.sv */
// Sequencing state machine for item execution and the two rotation copy passes.
module irr_ctrl import irr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.rotate_go ? S_COPY_OUT : S_RESULT;
            end
            S_COPY_OUT: begin
                o_cmd.copy_out = 1'b1;
                if (i_stat.copy_last) begin
                    n_state = S_DRAIN_OUT;
                end
            end
            S_DRAIN_OUT: begin
                n_state = S_COPY_BACK;
            end
            S_COPY_BACK: begin
                o_cmd.copy_back = 1'b1;
                if (i_stat.copy_last) begin
                    n_state = S_DRAIN_BACK;
                end
            end
            S_DRAIN_BACK: begin
                o_cmd.swap_dims = 1'b1;
                n_state         = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/irr_dp.sv */
// Datapath: item register, image and scratch memories, copy counters, result register.
module irr_dp import irr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    t_item                 r_item;
    logic [SIZE_BITS-1:0]  r_width;
    logic [SIZE_BITS-1:0]  r_height;
    t_status               r_status;
    logic [SIZE_BITS-1:0]  r_sw;
    logic [SIZE_BITS-1:0]  r_sh;
    logic [COORD_BITS-1:0] r_a;
    logic [COORD_BITS-1:0] r_b;
    logic                  r_pend_scr;
    logic                  r_pend_img;
    logic [ADDR_BITS-1:0]  r_pend_addr;
    logic [PIX_BITS-1:0]   r_img_mem [MEM_DEPTH];
    logic [PIX_BITS-1:0]   r_scr_mem [MEM_DEPTH];
    logic [PIX_BITS-1:0]   r_img_rd;
    logic [PIX_BITS-1:0]   r_scr_rd;
    t_result               r_res;
    logic                  r_out_valid;

    t_status               chk;
    logic [SIZE_BITS-1:0]  sel_w;
    logic [SIZE_BITS-1:0]  sel_h;
    logic                  a_last;
    logic                  b_last;
    logic                  pix_ok;
    logic [COORD_BITS-1:0] src_row;
    logic [COORD_BITS-1:0] src_col;
    logic [COORD_BITS-1:0] dst_row;
    logic [COORD_BITS-1:0] dst_col;
    logic                  img_we;
    logic [ADDR_BITS-1:0]  img_waddr;
    logic [PIX_BITS-1:0]   img_wdata;
    logic                  img_re;
    logic [ADDR_BITS-1:0]  img_raddr;

    function automatic logic [SIZE_BITS-1:0] clamp_dim(input logic [SIZE_BITS-1:0] v);
        logic [SIZE_BITS-1:0] r;
        if (v == '0) begin
            r = SIZE_BITS'(1);
        end else if (v > SIZE_BITS'(MAX_DIM)) begin
            r = SIZE_BITS'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign sel_w = r_item.sel_right - r_item.sel_left;
    assign sel_h = r_item.sel_bottom - r_item.sel_top;

    always_comb begin
        chk = ST_OK;
        unique case (r_item.action) inside
            ACT_NEW: begin
                chk = ST_OK;
            end
            ACT_WRITE, ACT_READ: begin
                if ({1'b0, r_item.pixel_row} >= r_height ||
                    {1'b0, r_item.pixel_col} >= r_width) begin
                    chk = ST_BAD_ADDR;
                end
            end
            ACT_ROTATE: begin
                if (r_item.sel_right > r_width || r_item.sel_bottom > r_height ||
                    r_item.sel_right <= r_item.sel_left ||
                    r_item.sel_bottom <= r_item.sel_top) begin
                    chk = ST_BAD_SEL;
                end else if (sel_w != sel_h &&
                             !(r_item.sel_left == '0 && r_item.sel_top == '0 &&
                               r_item.sel_right == r_width &&
                               r_item.sel_bottom == r_height)) begin
                    chk = ST_NOT_ROT;
                end
            end
            default: begin
                chk = ST_OK;
            end
        endcase
    end

    assign pix_ok  = (chk == ST_OK);
    assign a_last  = ({1'b0, r_a} == r_sw - SIZE_BITS'(1));
    assign b_last  = ({1'b0, r_b} == r_sh - SIZE_BITS'(1));

    // pass one reads old[bottom-1-b][left+a], pass two writes new[top+a][left+b]
    assign src_row = COORD_BITS'(r_item.sel_bottom - SIZE_BITS'(1) - {1'b0, r_b});
    assign src_col = COORD_BITS'(r_item.sel_left + {1'b0, r_a});
    assign dst_row = COORD_BITS'(r_item.sel_top + {1'b0, r_a});
    assign dst_col = COORD_BITS'(r_item.sel_left + {1'b0, r_b});

    assign o_stat.rotate_go = (r_item.action == ACT_ROTATE) && pix_ok;
    assign o_stat.copy_last = a_last && b_last;
    assign o_stat.out_free  = !r_out_valid || i_res_ready;

    always_comb begin
        img_we    = r_pend_img;
        img_waddr = r_pend_addr;
        img_wdata = r_scr_rd;
        if (i_cmd.exec && r_item.action == ACT_WRITE && pix_ok) begin
            img_we    = 1'b1;
            img_waddr = {r_item.pixel_row, r_item.pixel_col};
            img_wdata = r_item.pixel_in;
        end
        img_re    = i_cmd.copy_out;
        img_raddr = {src_row, src_col};
        if (i_cmd.exec && r_item.action == ACT_READ && pix_ok) begin
            img_re    = 1'b1;
            img_raddr = {r_item.pixel_row, r_item.pixel_col};
        end
    end

    always_ff @(posedge i_clk) begin
        if (img_we) begin
            r_img_mem[img_waddr] <= img_wdata;
        end
        if (img_re) begin
            r_img_rd <= r_img_mem[img_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend_scr) begin
            r_scr_mem[r_pend_addr] <= r_img_rd;
        end
        if (i_cmd.copy_back) begin
            r_scr_rd <= r_scr_mem[{r_a, r_b}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_status <= chk;
            r_sw     <= sel_w;
            r_sh     <= sel_h;
        end
        r_pend_addr <= i_cmd.copy_out ? {r_a, r_b} : {dst_row, dst_col};
        if (i_cmd.load_result) begin
            r_res.pixel_out  <= (r_item.action == ACT_READ && r_status == ST_OK) ?
                                r_img_rd : '0;
            r_res.status     <= r_status;
            r_res.cur_width  <= r_width;
            r_res.cur_height <= r_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= SIZE_BITS'(1);
            r_height    <= SIZE_BITS'(1);
            r_a         <= '0;
            r_b         <= '0;
            r_pend_scr  <= 1'b0;
            r_pend_img  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend_scr <= i_cmd.copy_out;
            r_pend_img <= i_cmd.copy_back;
            if (i_cmd.exec) begin
                r_a <= '0;
                r_b <= '0;
                if (r_item.action == ACT_NEW) begin
                    r_width  <= clamp_dim(r_item.new_width);
                    r_height <= clamp_dim(r_item.new_height);
                end
            end else if (i_cmd.copy_out || i_cmd.copy_back) begin
                if (b_last) begin
                    r_b <= '0;
                    r_a <= a_last ? '0 : r_a + COORD_BITS'(1);
                end else begin
                    r_b <= r_b + COORD_BITS'(1);
                end
            end
            if (i_cmd.swap_dims && r_sw != r_sh) begin
                r_width  <= r_sh;
                r_height <= r_sw;
            end
            if (i_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

/* rtl/image_region_rotate_90.sv */
// Top level of the image region rotate block: controller, datapath and checks.
//
// An item arrives on i_item (valid/ready); one result transaction leaves on
// o_result for every item, in order. Items are handled one at a time.
// New image, pixel write, pixel read and rejected rotation pass through the
// execute and result states; an accepted rotation also runs copy-out, drain,
// copy-back and drain before the result state.
// A rotation makes two passes over the selection through the single
// read and write port of each memory: image to scratch, then scratch back.
// A new item can be taken in the cycle after the previous result is loaded
// into the output register.
// The output register holds a result while o_result.ready is low; the next
// item is still accepted and executed, then waits until that register frees.
// Reset sets the image to 1 x 1 and clears all handshake state. Pixel memory
// contents are not cleared; pixels never written read back as unknown.
module image_region_rotate_90 import irr_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    irr_item_if.sink    i_item,
    irr_result_if.source o_result
);

    t_item   w_item;
    t_cmd    w_cmd;
    t_stat   w_stat;
    t_result w_res;
    logic    w_res_valid;
    logic    w_in_ready;

    assign w_item.action     = i_item.action;
    assign w_item.pixel_row  = i_item.pixel_row;
    assign w_item.pixel_col  = i_item.pixel_col;
    assign w_item.pixel_in   = i_item.pixel_in;
    assign w_item.new_width  = i_item.new_width;
    assign w_item.new_height = i_item.new_height;
    assign w_item.sel_left   = i_item.sel_left;
    assign w_item.sel_top    = i_item.sel_top;
    assign w_item.sel_right  = i_item.sel_right;
    assign w_item.sel_bottom = i_item.sel_bottom;

    irr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    irr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_result.ready),
        .o_res       (w_res)
    );

    assign i_item.ready        = w_in_ready;
    assign o_result.valid      = w_res_valid;
    assign o_result.pixel_out  = w_res.pixel_out;
    assign o_result.status     = w_res.status;
    assign o_result.cur_width  = w_res.cur_width;
    assign o_result.cur_height = w_res.cur_height;

    // one item in flight: ready drops right after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> !i_item.ready)
        else $error("item accepted while another is in progress");

    a_dims_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.cur_width != '0 && o_result.cur_height != '0 &&
            o_result.cur_width <= SIZE_BITS'(MAX_DIM) &&
            o_result.cur_height <= SIZE_BITS'(MAX_DIM))
        else $error("image dimensions out of range");

    a_pix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.status != ST_OK |-> o_result.pixel_out == '0)
        else $error("nonzero pixel on failed transaction");

    a_no_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_result |-> !o_result.valid || o_result.ready)
        else $error("result overwritten before it was taken");

endmodule

/* tb/image_region_rotate_90_tb.sv */
// Testbench for image_region_rotate_90: directed and random transactions checked against a local image model.
`timescale 1ns / 100ps

module image_region_rotate_90_tb;
    import irr_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    irr_item_if   item_ch ();
    irr_result_if result_ch ();

    image_region_rotate_90 dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // image model state
    logic [PIX_BITS-1:0] pix_mem     [MEM_DEPTH];
    bit                  pix_written [MEM_DEPTH];
    logic [PIX_BITS-1:0] rot_pix     [MEM_DEPTH];
    bit                  rot_written [MEM_DEPTH];
    int                  img_w = 1;
    int                  img_h = 1;

    t_result due_results [$];
    int      mismatches = 0;
    bit      tx_idle = 1'b0;
    bit      rx_idle = 1'b0;
    int      rx_hold = 0;

    function automatic int dim_clamp(logic [SIZE_BITS-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic t_status sel_check(int lft, int tp, int rgt, int bot);
        if (rgt > img_w || bot > img_h || rgt <= lft || bot <= tp) return ST_BAD_SEL;
        if ((rgt - lft) != (bot - tp) &&
            !(lft == 0 && tp == 0 && rgt == img_w && bot == img_h)) return ST_NOT_ROT;
        return ST_OK;
    endfunction

    function automatic t_result apply_to_image(t_item it);
        t_result res;
        int      sw, sh, lft, tp, idx, src, r, c;
        res.pixel_out = '0;
        res.status    = ST_OK;
        case (it.action) inside
            ACT_NEW: begin
                img_w = dim_clamp(it.new_width);
                img_h = dim_clamp(it.new_height);
            end
            ACT_WRITE, ACT_READ: begin
                if (it.pixel_row >= img_h || it.pixel_col >= img_w) begin
                    res.status = ST_BAD_ADDR;
                end else begin
                    idx = int'(it.pixel_row) * MAX_DIM + int'(it.pixel_col);
                    if (it.action == ACT_WRITE) begin
                        pix_mem[idx]     = it.pixel_in;
                        pix_written[idx] = 1'b1;
                    end else begin
                        res.pixel_out = pix_mem[idx];
                    end
                end
            end
            default: begin
                res.status = sel_check(int'(it.sel_left), int'(it.sel_top),
                                       int'(it.sel_right), int'(it.sel_bottom));
                if (res.status == ST_OK) begin
                    lft = int'(it.sel_left);
                    tp  = int'(it.sel_top);
                    sw  = int'(it.sel_right) - lft;
                    sh  = int'(it.sel_bottom) - tp;
                    // new[r][c] = old[sh-1-c][r]
                    for (r = 0; r < sw; r++) begin
                        for (c = 0; c < sh; c++) begin
                            src = (tp + sh - 1 - c) * MAX_DIM + lft + r;
                            rot_pix[r * MAX_DIM + c]     = pix_mem[src];
                            rot_written[r * MAX_DIM + c] = pix_written[src];
                        end
                    end
                    for (r = 0; r < sw; r++) begin
                        for (c = 0; c < sh; c++) begin
                            idx = (tp + r) * MAX_DIM + lft + c;
                            pix_mem[idx]     = rot_pix[r * MAX_DIM + c];
                            pix_written[idx] = rot_written[r * MAX_DIM + c];
                        end
                    end
                    if (sw != sh) begin
                        img_w = sh;
                        img_h = sw;
                    end
                end
            end
        endcase
        res.cur_width  = SIZE_BITS'(img_w);
        res.cur_height = SIZE_BITS'(img_h);
        return res;
    endfunction

    function automatic t_item random_fields();
        t_item it;
        it.action     = t_action'($urandom_range(0, 3));
        it.pixel_row  = COORD_BITS'($urandom);
        it.pixel_col  = COORD_BITS'($urandom);
        it.pixel_in   = PIX_BITS'($urandom);
        it.new_width  = SIZE_BITS'($urandom);
        it.new_height = SIZE_BITS'($urandom);
        it.sel_left   = SIZE_BITS'($urandom);
        it.sel_top    = SIZE_BITS'($urandom);
        it.sel_right  = SIZE_BITS'($urandom);
        it.sel_bottom = SIZE_BITS'($urandom);
        return it;
    endfunction

    task automatic issue_item(t_item it);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.action     <= it.action;
        item_ch.pixel_row  <= it.pixel_row;
        item_ch.pixel_col  <= it.pixel_col;
        item_ch.pixel_in   <= it.pixel_in;
        item_ch.new_width  <= it.new_width;
        item_ch.new_height <= it.new_height;
        item_ch.sel_left   <= it.sel_left;
        item_ch.sel_top    <= it.sel_top;
        item_ch.sel_right  <= it.sel_right;
        item_ch.sel_bottom <= it.sel_bottom;
        item_ch.valid      <= 1'b1;
        do @(posedge i_clk); while (!item_ch.ready);
        due_results.push_back(apply_to_image(it));
    endtask

    // writes every pixel of the region that holds no value yet
    task automatic cover_region(int tp, int lft, int rows, int cols);
        t_item it;
        int    r, c;
        for (r = 0; r < rows; r++) begin
            for (c = 0; c < cols; c++) begin
                if (!pix_written[(tp + r) * MAX_DIM + lft + c]) begin
                    it           = random_fields();
                    it.action    = ACT_WRITE;
                    it.pixel_row = COORD_BITS'(tp + r);
                    it.pixel_col = COORD_BITS'(lft + c);
                    issue_item(it);
                end
            end
        end
    endtask

    task automatic send_new(int w, int h);
        t_item it;
        it            = random_fields();
        it.action     = ACT_NEW;
        it.new_width  = SIZE_BITS'(w);
        it.new_height = SIZE_BITS'(h);
        issue_item(it);
    endtask

    task automatic send_pixel(t_action act, int row, int col, int val);
        t_item it;
        if (act == ACT_READ && row < img_h && col < img_w) cover_region(row, col, 1, 1);
        it           = random_fields();
        it.action    = act;
        it.pixel_row = COORD_BITS'(row);
        it.pixel_col = COORD_BITS'(col);
        it.pixel_in  = PIX_BITS'(val);
        issue_item(it);
    endtask

    task automatic send_rotate(int lft, int tp, int rgt, int bot);
        t_item it;
        if (sel_check(lft, tp, rgt, bot) == ST_OK) cover_region(tp, lft, bot - tp, rgt - lft);
        it            = random_fields();
        it.action     = ACT_ROTATE;
        it.sel_left   = SIZE_BITS'(lft);
        it.sel_top    = SIZE_BITS'(tp);
        it.sel_right  = SIZE_BITS'(rgt);
        it.sel_bottom = SIZE_BITS'(bot);
        issue_item(it);
    endtask

    function automatic int rand_dim();
        int p;
        p = $urandom_range(0, 9);
        if (p < 8) return $urandom_range(1, 12);
        if (p == 8) return $urandom_range(1, MAX_DIM);
        return $urandom_range(0, 511);
    endfunction

    function automatic int rand_coord(int lim);
        if ($urandom_range(0, 6) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic int noisy_bound(int lim);
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 511);
        return $urandom_range(0, lim + 1);
    endfunction

    task automatic random_rotate();
        int pick, m, s, lft, tp, rgt, bot;
        pick = $urandom_range(0, 9);
        m    = (img_w < img_h) ? img_w : img_h;
        if (pick < 5 || (pick < 7 && img_w * img_h > 256)) begin
            if (m <= 16 && $urandom_range(0, 3) == 0)
                s = m;
            else
                s = $urandom_range(1, (m < 8) ? m : 8);
            lft = $urandom_range(0, img_w - s);
            tp  = $urandom_range(0, img_h - s);
            send_rotate(lft, tp, lft + s, tp + s);
        end else if (pick < 7) begin
            send_rotate(0, 0, img_w, img_h);
        end else begin
            lft = noisy_bound(img_w);
            tp  = noisy_bound(img_h);
            rgt = noisy_bound(img_w);
            bot = noisy_bound(img_h);
            // keep accepted noise small enough to fill
            if (sel_check(lft, tp, rgt, bot) == ST_OK && (rgt - lft) * (bot - tp) > 256)
                rgt = 0;
            send_rotate(lft, tp, rgt, bot);
        end
    endtask

    task automatic random_traffic(int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                send_new(rand_dim(), rand_dim());
            else if (pick < 45)
                send_pixel(ACT_WRITE, rand_coord(img_h), rand_coord(img_w),
                           $urandom_range(0, 255));
            else if (pick < 75)
                send_pixel(ACT_READ, rand_coord(img_h), rand_coord(img_w), 0);
            else
                random_rotate();
        end
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_new(0, 0);
        send_pixel(ACT_READ, 0, 1, 0);
        send_new(300, 511);
        send_pixel(ACT_WRITE, 255, 255, 255);
        send_pixel(ACT_WRITE, 0, 0, 0);
        send_pixel(ACT_READ, 255, 255, 0);
        send_rotate(254, 254, 256, 256);
        send_pixel(ACT_READ, 254, 255, 0);
        send_rotate(0, 0, 257, 256);
        send_rotate(5, 0, 5, 1);
        send_rotate(0, 3, 1, 3);
        send_rotate(0, 0, 2, 1);
        send_new(2, 1);
        send_rotate(0, 0, 2, 1);
        send_pixel(ACT_READ, 1, 0, 0);
        send_pixel(ACT_WRITE, 0, 1, 8'hAA);
        send_new(1, 1);
        send_rotate(0, 0, 1, 1);
        drain_results();
    endtask

    task automatic test_random_with_gaps();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        random_traffic(250);
        drain_results();
    endtask

    task automatic test_random_streaming();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        random_traffic(120);
        drain_results();
    endtask

    task automatic test_output_stall();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold = 300;
        random_traffic(40);
        drain_results();
    endtask

    task automatic test_one_sided_idling();
        tx_idle = 1'b1;
        rx_idle = 1'b0;
        random_traffic(70);
        drain_results();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        random_traffic(70);
        drain_results();
    endtask

    task automatic check_field(string name, logic [8:0] want, logic [8:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual status %0d",
                         $time, result_ch.status);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("pixel_out", 9'(want.pixel_out), 9'(result_ch.pixel_out));
                check_field("status", 9'(want.status), 9'(result_ch.status));
                check_field("cur_width", want.cur_width, result_ch.cur_width);
                check_field("cur_height", want.cur_height, result_ch.cur_height);
            end
        end
    end

    initial begin
        int stall;
        result_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = rx_idle ? $urandom_range(0, 9) : 0;
            end
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.action     <= ACT_NEW;
        item_ch.pixel_row  <= '0;
        item_ch.pixel_col  <= '0;
        item_ch.pixel_in   <= '0;
        item_ch.new_width  <= '0;
        item_ch.new_height <= '0;
        item_ch.sel_left   <= '0;
        item_ch.sel_top    <= '0;
        item_ch.sel_right  <= '0;
        item_ch.sel_bottom <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_with_gaps();
        test_random_streaming();
        test_output_stall();
        test_one_sided_idling();

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
